// File: rtl/jis_pkg.sv
// package: shared types and constants of the jacobi solver
package jis_pkg;
  localparam int MaxSize = 16;
  localparam int IdxW = 4;

  typedef enum logic [1:0] {
    MODE_MAT = 2'd0,
    MODE_RHS = 2'd1,
    MODE_EST = 2'd2,
    MODE_START = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CONV = 2'd0,
    ST_LIMIT = 2'd1,
    ST_ZDIAG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_SIZE = 2'd0,
    CFG_TOL = 2'd1,
    CFG_MAXIT = 2'd2
  } cfg_idx_t;

  // divider control and status
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;
endpackage

// File: rtl/jacobi_iterative_solver_unit.sv
// top level: jacobi solver with stores, sequencer and shared units
// Jacobi solver for A x = b in signed Q16.16. Load items (mode 0..2) are stored
// while idle. A start item checks the n diagonals, then, unless one is zero, runs
// sweeps; each row streams n coefficient reads through one multiplier, then goes
// through one shared divider; then come the step norm, the copy and the decision.
// Results then leave one per cycle, each for exactly one cycle on out_valid; the
// receiver cannot stall them. busy stays high from start and drops in the cycle
// the last result is shown.
module jacobi_iterative_solver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_col,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  output logic [3:0]  out_index,
  output logic signed [31:0] out_solution,
  output logic [15:0] out_iterations,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIAG  = 9'b000000010,
    S_MAC   = 9'b000000100,
    S_DIVGO = 9'b000001000,
    S_DIVW  = 9'b000010000,
    S_NORM  = 9'b000100000,
    S_COPY  = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_DECI  = 9'b100000000
  } state_t;

  state_t state_r;
  logic [4:0]  size_r;
  logic [30:0] tol_r;
  logic [15:0] maxit_r;
  logic [4:0]  n;
  logic [31:0] coef_mem [256];
  logic [31:0] rhs_r [16];
  logic [31:0] est_r [16];
  logic [31:0] nxt_r [16];
  logic [3:0]  i_r, j_r;
  logic [4:0]  jc_r;
  logic [31:0] coef_q;
  logic        mvalid_r;
  logic [3:0]  mj_r;
  logic        mskip_r;
  logic signed [63:0] prod_r;
  logic        pvalid_r;
  logic signed [52:0] acc_r;
  logic [31:0] diag_r;
  logic [15:0] count_r;
  logic [63:0] norm_r;
  logic [61:0] tol2;
  logic [1:0]  status_r;
  logic zdiag_r;
  logic signed [32:0] dif;
  logic [31:0] adif;
  logic [63:0] sq;
  logic [64:0] nsum;
  logic signed [53:0] num;
  logic signed [47:0] numc;
  jis_pkg::div_req_t dreq;
  jis_pkg::div_rsp_t drsp;
  logic [7:0] raddr;
  logic acc_in;

  always_comb begin
    if (size_r == 5'd0) n = 5'd1;
    else if (size_r > 5'(jis_pkg::MaxSize)) n = 5'(jis_pkg::MaxSize);
    else n = size_r;
  end

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign acc_in = start && !busy;
  assign tol2 = 62'(tol_r) * 62'(tol_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 5'd16;
      tol_r <= 31'd66;
      maxit_r <= 16'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jis_pkg::CFG_SIZE:  size_r <= cfg_data[4:0];
        jis_pkg::CFG_TOL:   tol_r <= cfg_data[30:0];
        jis_pkg::CFG_MAXIT: maxit_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // coefficient memory read address
  always_comb begin
    if (state_r == S_DIAG) raddr = {jc_r[3:0], jc_r[3:0]};
    else if (state_r == S_MAC) raddr = {i_r, j_r};
    else raddr = {i_r, i_r};
  end

  always_ff @(posedge clk) begin
    if (acc_in && in_mode == jis_pkg::MODE_MAT) coef_mem[{in_row, in_col}] <= in_value;
    coef_q <= coef_mem[raddr];
  end

  // per-term arithmetic
  assign num = 54'(signed'(rhs_r[i_r])) - 54'(acc_r);
  always_comb begin
    if (num > 54'sd70368744177664) numc = 48'sd70368744177664;
    else if (num < -54'sd70368744177664) numc = -48'sd70368744177664;
    else numc = num[47:0];
  end
  // divider request: start, numerator scaled by 2^16, diagonal
  assign dreq = {state_r == S_DIVGO, numc, 16'd0, diag_r};
  assign dif = 33'(signed'(nxt_r[i_r])) - 33'(signed'(est_r[i_r]));
  assign adif = dif[32] ? 32'(-dif) : dif[31:0];
  assign sq = 64'(adif) * 64'(adif);
  assign nsum = {1'b0, norm_r} + {1'b0, sq};

  jis_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mvalid_r <= 1'b0;
      pvalid_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      pvalid_r <= mvalid_r && !mskip_r;
      mvalid_r <= 1'b0;
      if (mvalid_r) prod_r <= signed'(coef_q) * signed'(est_r[mj_r]);
      if (pvalid_r) acc_r <= acc_r + 53'(prod_r >>> 16);
      unique case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            unique case (in_mode)
              jis_pkg::MODE_RHS: rhs_r[in_row] <= in_value;
              jis_pkg::MODE_EST: est_r[in_row] <= in_value;
              jis_pkg::MODE_START: begin
                state_r <= S_DIAG;
                jc_r <= '0;
                zdiag_r <= 1'b0;
                count_r <= '0;
              end
              default: ;
            endcase
          end
        end
        S_DIAG: begin
          jc_r <= jc_r + 5'd1;
          mvalid_r <= 1'b1;
          if (mvalid_r && coef_q == 32'd0) zdiag_r <= 1'b1;
          if (jc_r >= n) mvalid_r <= 1'b0;
          if (jc_r == n + 5'd2) begin
            if (zdiag_r) begin
              status_r <= jis_pkg::ST_ZDIAG;
              state_r <= S_OUT;
              i_r <= '0;
            end else begin
              state_r <= S_MAC;
              i_r <= '0;
              j_r <= '0;
              jc_r <= '0;
              acc_r <= '0;
              norm_r <= '0;
            end
          end
        end
        S_MAC: begin
          if (jc_r < n) begin
            mvalid_r <= 1'b1;
            mj_r <= j_r;
            mskip_r <= (j_r == i_r);
            j_r <= j_r + 4'd1;
          end
          jc_r <= jc_r + 5'd1;
          if (jc_r == n + 5'd4) state_r <= S_DIVGO;
          if (jc_r == n + 5'd1) diag_r <= 32'd0;
        end
        S_DIVGO: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (drsp.done) begin
            nxt_r[i_r] <= drsp.quo;
            acc_r <= '0;
            j_r <= '0;
            jc_r <= '0;
            if (5'(i_r) == n - 5'd1) begin
              i_r <= '0;
              state_r <= S_NORM;
            end else begin
              i_r <= i_r + 4'd1;
              state_r <= S_MAC;
            end
          end
        end
        S_NORM: begin
          norm_r <= nsum[64] ? 64'hFFFFFFFFFFFFFFFF : nsum[63:0];
          if (5'(i_r) == n - 5'd1) begin
            i_r <= '0;
            state_r <= S_COPY;
            count_r <= count_r + 16'd1;
          end else i_r <= i_r + 4'd1;
        end
        S_COPY: begin
          est_r[i_r] <= nxt_r[i_r];
          if (5'(i_r) == n - 5'd1) begin
            i_r <= '0;
            state_r <= S_DECI;
          end else i_r <= i_r + 4'd1;
        end
        S_DECI: begin
          if (norm_r >= 64'(tol2) && count_r < maxit_r) begin
            state_r <= S_MAC;
            norm_r <= '0;
          end else begin
            status_r <= (norm_r >= 64'(tol2)) ? jis_pkg::ST_LIMIT : jis_pkg::ST_CONV;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_index <= i_r;
          out_solution <= est_r[i_r];
          out_iterations <= count_r;
          out_status <= status_r;
          out_last <= (5'(i_r) == n - 5'd1);
          if (5'(i_r) == n - 5'd1) state_r <= S_IDLE;
          else i_r <= i_r + 4'd1;
        end
        default: state_r <= S_IDLE;
      endcase
      // latch the diagonal once the row's mac reads have drained
      if (state_r == S_MAC && jc_r == n + 5'd2) diag_r <= coef_mem[{i_r, i_r}];
    end
  end

  // a result only leaves while busy was set
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without busy");
  // no config acceptance while solving
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready) else $error("config ready while busy");
  // last result ends the run
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy) else $error("busy after last");
endmodule

// File: rtl/jis_divider.sv
// divider: signed restoring division, one quotient bit per cycle, saturated to 32 bits
module jis_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  jis_pkg::div_req_t req,
  output jis_pkg::div_rsp_t rsp
);
  logic [63:0] a_r, a_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic        neg_r;
  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [64:0] trial;
  logic [63:0] qabs;
  logic signed [64:0] qs;
  logic [31:0] quo;

  assign trial = {rem_r[63:0], a_r[63]} - {33'd0, d_r};
  assign rem_nxt = trial[64] ? {rem_r[63:0], a_r[63]} : trial;
  assign a_nxt = {a_r[62:0], ~trial[64]};
  assign qabs = a_r;
  assign qs = neg_r ? -$signed({1'b0, qabs}) : $signed({1'b0, qabs});
  assign rsp = {done_r, quo};

  // iterate over the quotient bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.num[63] ? -req.num : req.num;
      d_r <= req.den[31] ? -req.den : req.den;
      neg_r <= req.num[63] ^ req.den[31];
      rem_r <= '0;
    end else if (busy_r) begin
      a_r <= a_nxt;
      rem_r <= rem_nxt;
    end
  end

  // saturate the finished quotient
  always_comb begin
    if (qs > 65'sh7FFFFFFF) quo = 32'h7FFFFFFF;
    else if (qs < -65'sh80000000) quo = 32'h80000000;
    else quo = qs[31:0];
  end
endmodule

// File: dv/tb.sv
// testbench of the jacobi solver: directed and random systems checked against a predictor
`timescale 1ns / 100ps

module tb;
  import jis_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int RandomItems = 420;
  localparam int CalmFrom = 380;
  localparam longint NumLim = 64'sh0000_4000_0000_0000;

  typedef struct {
    logic [3:0]         index;
    logic signed [31:0] solution;
    logic [15:0]        iterations;
    status_t            status;
    logic               last;
  } solution_t;

  // predictor of the solver plus queue of solution elements still to come
  class jacobi_board;
    int a_mat[16][16];
    int b_vec[16];
    int x_vec[16];
    int unsigned size_r;
    longint unsigned tol_r;
    int unsigned maxit_r;
    solution_t pending_q[$];
    int errors;

    function new();
      size_r = 16;
      tol_r = 66;
      maxit_r = 1024;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] d);
      case (idx)
        CFG_SIZE: size_r = d[4:0];
        CFG_TOL: tol_r = d[30:0];
        CFG_MAXIT: maxit_r = d[15:0];
        default: ;
      endcase
    endfunction

    // one sweep, returns the squared step norm in Q32.32
    function longint unsigned sweep(int n);
      longint acc, num, quo, d;
      longint unsigned ad, sq, norm;
      int nx[16];
      norm = 0;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++)
          if (j != i) acc += (longint'(a_mat[i][j]) * longint'(x_vec[j])) >>> 16;
        num = longint'(b_vec[i]) - acc;
        if (num > NumLim) num = NumLim;
        if (num < -NumLim) num = -NumLim;
        quo = (num * 64'sd65536) / longint'(a_mat[i][i]);
        if (quo > 64'sd2147483647) nx[i] = 32'h7fffffff;
        else if (quo < -64'sd2147483648) nx[i] = 32'h80000000;
        else nx[i] = int'(quo);
      end
      for (int i = 0; i < n; i++) begin
        d = longint'(nx[i]) - longint'(x_vec[i]);
        ad = (d < 0) ? longint'(-d) : longint'(d);
        sq = ad * ad;
        if (norm > ~64'd0 - sq) norm = ~64'd0;
        else norm += sq;
      end
      for (int i = 0; i < n; i++) x_vec[i] = nx[i];
      return norm;
    endfunction

    // note one accepted item, predict solution elements for a start
    function void note_item(mode_t m, int r, int c, int v);
      int n;
      int unsigned cnt;
      status_t st;
      longint unsigned tol2, norm;
      solution_t s;
      case (m)
        MODE_MAT: a_mat[r][c] = v;
        MODE_RHS: b_vec[r] = v;
        MODE_EST: x_vec[r] = v;
        default: begin
          n = (size_r == 0) ? 1 : ((size_r > 16) ? 16 : size_r);
          st = ST_CONV;
          cnt = 0;
          for (int i = 0; i < n; i++)
            if (a_mat[i][i] == 0) st = ST_ZDIAG;
          if (st != ST_ZDIAG) begin
            tol2 = tol_r * tol_r;
            do begin
              norm = sweep(n);
              cnt++;
            end while (norm >= tol2 && cnt < maxit_r);
            st = (norm >= tol2) ? ST_LIMIT : ST_CONV;
          end
          for (int i = 0; i < n; i++) begin
            s.index = 4'(i);
            s.solution = x_vec[i];
            s.iterations = cnt[15:0];
            s.status = st;
            s.last = (i == n - 1);
            pending_q.push_back(s);
          end
        end
      endcase
    endfunction

    // compare one result with the oldest expected element
    function void check(solution_t got);
      solution_t e;
      if (pending_q.size() == 0) begin
        $error("solution element index %0d with nothing expected", got.index);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.index !== e.index) begin
        $error("index expected %0d actual %0d", e.index, got.index);
        errors++;
      end
      if (got.solution !== e.solution) begin
        $error("solution expected %0d actual %0d", e.solution, got.solution);
        errors++;
      end
      if (got.iterations !== e.iterations) begin
        $error("iterations expected %0d actual %0d", e.iterations, got.iterations);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last expected %0d actual %0d", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = MODE_MAT;
  logic [3:0] in_row = '0;
  logic [3:0] in_col = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic [3:0] out_index;
  logic signed [31:0] out_solution;
  logic [15:0] out_iterations;
  logic [1:0] out_status;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_SIZE;
  logic [31:0] cfg_data = '0;

  jacobi_board sb;
  int n_items = 0;
  int cycles = 0;
  int act_n = 16;
  bit start_hi = 0;
  bit wr_a[16][16];
  bit wr_b[16];
  bit wr_x[16];

  jacobi_iterative_solver_unit DUT (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    solution_t got;
    if (rst_n && out_valid) begin
      got.index = out_index;
      got.solution = out_solution;
      got.iterations = out_iterations;
      got.status = status_t'(out_status);
      got.last = out_last;
      sb.check(got);
    end
  end

  task automatic drop_start();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 0;
    end
  endtask

  // send one item, with a random gap before it outside the calm tail
  task automatic put_item(mode_t m, int r, int c, int v);
    int g;
    if (n_items < CalmFrom && $urandom_range(0, 5) == 0) begin
      drop_start();
      g = $urandom_range(1, 19);
      repeat (g) @(posedge clk);
    end
    start <= 1'b1;
    start_hi = 1;
    in_mode <= m;
    in_row <= 4'(r);
    in_col <= 4'(c);
    in_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(m, r, c, v);
    n_items++;
    case (m)
      MODE_MAT: wr_a[r][c] = 1;
      MODE_RHS: wr_b[r] = 1;
      MODE_EST: wr_x[r] = 1;
      default: ;
    endcase
  endtask

  // wait for every expected element, then for the block to settle
  task automatic drain();
    drop_start();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // write all three registers while the block is idle
  task automatic set_cfg(int unsigned size, int unsigned tol, int unsigned maxit);
    logic [31:0] d;
    drain();
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: d = {27'($urandom() >> 5), size[4:0]};
        1: d = {$urandom_range(0, 1) == 1, tol[30:0]};
        default: d = {16'($urandom() >> 16), maxit[15:0]};
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(k);
      cfg_data <= d;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_reg(cfg_idx_t'(k), d);
    end
    cfg_valid <= 1'b0;
    act_n = (size[4:0] == 0) ? 1 : ((size[4:0] > 16) ? 16 : size[4:0]);
  endtask

  function automatic bit covered(int n);
    for (int i = 0; i < n; i++) begin
      if (!wr_b[i] || !wr_x[i]) return 0;
      for (int j = 0; j < n; j++)
        if (!wr_a[i][j]) return 0;
    end
    return 1;
  endfunction

  function automatic int wild_val();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 0;
      default: return $urandom();
    endcase
  endfunction

  // entry value: tame values keep the matrix diagonally dominant
  function automatic int pick_val(bit wild, bit diag, int n);
    int mag;
    if (wild) return wild_val();
    if (diag) begin
      mag = (n + 1) * 65536 + $urandom_range(0, 4 * 65536);
      return $urandom_range(0, 1) ? mag : -mag;
    end
    return $urandom_range(0, 131072) - 65536;
  endfunction

  // load a whole system of the active size, in random row order
  task automatic load_system(bit wild, bit zdiag);
    int n, zrow, r;
    int perm[$];
    n = act_n;
    zrow = zdiag ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) perm.push_back(i);
    perm.shuffle();
    foreach (perm[k]) begin
      r = perm[k];
      for (int j = 0; j < n; j++)
        put_item(MODE_MAT, r, j, (r == zrow && j == r) ? 0 : pick_val(wild, r == j, n));
      put_item(MODE_RHS, r, 0, wild ? wild_val() : $urandom_range(0, 2097152) - 1048576);
      put_item(MODE_EST, r, $urandom_range(0, 15),
               wild ? wild_val() : $urandom_range(0, 2097152) - 1048576);
    end
  endtask

  // stimulus
  initial begin
    bit wild, big;
    int unsigned tol, maxit;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: saturating extremes on a 2x2 system
    set_cfg(2, 66, 4);
    put_item(MODE_MAT, 0, 0, 32'h7fffffff);
    put_item(MODE_MAT, 0, 1, 32'h80000000);
    put_item(MODE_MAT, 1, 0, 32'h80000000);
    put_item(MODE_MAT, 1, 1, 32'h00010000);
    put_item(MODE_RHS, 0, 15, 32'h80000000);
    put_item(MODE_RHS, 1, 0, 32'h7fffffff);
    put_item(MODE_EST, 0, 0, 0);
    put_item(MODE_EST, 1, 15, 32'h80000000);
    put_item(MODE_START, 0, 0, 0);
    // zero diagonal, then stored but unused corner entry
    put_item(MODE_MAT, 1, 1, 0);
    put_item(MODE_START, 15, 15, -1);
    put_item(MODE_MAT, 1, 1, 32'h00008000);
    put_item(MODE_MAT, 15, 15, -1);
    // sweep limit of zero still runs one sweep
    set_cfg(2, 0, 0);
    put_item(MODE_START, 0, 0, 0);
    // size zero acts as one, widest tolerance
    set_cfg(0, 31'h7fffffff, 1);
    put_item(MODE_START, 0, 0, 0);

    // full size system, then oversize setting resumes from it
    set_cfg(16, $urandom_range(0, 1000), 2);
    load_system(0, 0);
    put_item(MODE_START, 0, 0, 0);
    set_cfg(31, 0, 1);
    put_item(MODE_START, 0, 0, 0);
    set_cfg(17, 31'h7fffffff, 65535);
    put_item(MODE_START, 0, 0, 0);

    // random phases
    while (n_items < RandomItems) begin
      case ($urandom_range(0, 3))
        0: tol = 0;
        1: tol = $urandom_range(1, 200);
        2: tol = $urandom_range(1000, 100000);
        default: tol = 31'h7fffffff;
      endcase
      wild = ($urandom_range(0, 3) == 0);
      big = !wild && tol >= 1000 && $urandom_range(0, 2) == 0;
      if (big) maxit = 65535;
      else if (!wild && tol >= 1000) maxit = $urandom_range(1, 40);
      else maxit = $urandom_range(1, 8);
      set_cfg($urandom_range(0, 6), tol, maxit);
      repeat ($urandom_range(1, 3)) begin
        if (!big && covered(act_n) && $urandom_range(0, 3) == 0) begin
          // resume from the kept estimate, sometimes with a new right-hand side
          if ($urandom_range(0, 1))
            put_item(MODE_RHS, $urandom_range(0, act_n - 1), $urandom_range(0, 15),
                     wild ? wild_val() : $urandom_range(0, 2097152) - 1048576);
          put_item(MODE_START, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
        end else begin
          repeat ($urandom_range(0, 3))
            put_item(mode_t'($urandom_range(0, 2)), $urandom_range(0, 15),
                     $urandom_range(0, 15), wild_val());
          load_system(wild, $urandom_range(0, 7) == 0);
          put_item(MODE_START, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/jis_pkg.sv
rtl/jis_divider.sv
rtl/jacobi_iterative_solver_unit.sv
dv/tb.sv
